// ===== design/nmea_line_framer_checksum_assert.svh =====
// ----------------------------------------------------------------------------
// nmea line framer assertion macros
// shared concurrent assertion forms, clocked on clk, held off by arst_n
// ----------------------------------------------------------------------------
`ifndef NMEA_LINE_FRAMER_CHECKSUM_ASSERT_SVH
`define NMEA_LINE_FRAMER_CHECKSUM_ASSERT_SVH

// same-cycle implication
`define NLFC_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define NLFC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/nlfc_pkg.sv =====
// ----------------------------------------------------------------------------
// nlfc_pkg
// shared types, character codes and lookup functions of the nmea line framer
// ----------------------------------------------------------------------------
package nlfc_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// saturating counters only need to reach the thresholds
	localparam int TEXT_CNT_W = 3;
	localparam logic [TEXT_CNT_W-1:0] TEXT_MIN = 3'd7;
	localparam int TAIL_CNT_W = 2;
	localparam logic [TAIL_CNT_W-1:0] TAIL_MIN = 2'd2;

	// sentence type letters sit at these line positions
	localparam int POS_TYPE0 = 3;
	localparam int POS_TYPE1 = 4;
	localparam int POS_TYPE2 = 5;

	typedef enum logic [2:0] {
		VERDICT_GOOD     = 3'd0,
		VERDICT_AIS_FWD  = 3'd1,
		VERDICT_SHORT    = 3'd2,
		VERDICT_BAD_STAR = 3'd3,
		VERDICT_MISMATCH = 3'd4,
		VERDICT_AIS_REJ  = 3'd5
	} verdict_t;

	typedef logic [3:0] kind_t;
	localparam kind_t KIND_OTHER = 4'd0;
	localparam int NUM_KINDS = 10;

	localparam logic [23:0] KIND_NAMES [NUM_KINDS] = '{
		"HDT", "HDG", "VTG", "RMC", "MWV", "DBT", "DPT", "MTW", "XTE", "RMB"
	};

	// summary of one finished line, passed from framer to checker
	typedef struct packed {
		logic        lead_bang;
		logic        lead_dollar;
		logic        text_ok;
		logic        star_ok;
		logic [7:0]  star_xor;
		logic [7:0]  tail_hex;
		logic [23:0] type_letters;
	} line_sum_t;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// {valid, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]})
			r = {1'b1, 4'(c - 8'h30)};
		else if (c inside {[8'h61:8'h66]})
			r = {1'b1, 4'(c - 8'h61 + 8'd10)};
		else if (c inside {[8'h41:8'h46]})
			r = {1'b1, 4'(c - 8'h41 + 8'd10)};
		return r;
	endfunction

	function automatic kind_t classify(input logic [23:0] letters);
		kind_t k;
		k = KIND_OTHER;
		for (int i = NUM_KINDS - 1; i >= 0; i--) begin
			if (letters == KIND_NAMES[i])
				k = kind_t'(i + 1);
		end
		return k;
	endfunction

endpackage

// ===== design/nlfc_front.sv =====
// ----------------------------------------------------------------------------
// nlfc_front
// line framer: folds each accepted byte into running line state, drops the line
// on overflow, and emits a line summary on every terminator that closes a non-empty line
// ----------------------------------------------------------------------------
`include "nmea_line_framer_checksum_assert.svh"

module nlfc_front #(
	parameter int LINE_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_fire,
	input  logic [7:0]         rx_byte,
	output logic               push,
	output nlfc_pkg::line_sum_t sum
);

	localparam int LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic [nlfc_pkg::TEXT_CNT_W-1:0] text_cnt;
		logic [7:0]                      lead;
		logic [7:0]                      body_xor;
		logic [7:0]                      star_xor;
		logic                            star;
		logic [nlfc_pkg::TAIL_CNT_W-1:0] tail_cnt;
		logic [7:0]                      tail_hex;
		logic                            hex_end;
		logic [23:0]                     letters;
		logic                            nul;
	} line_state_t;

	line_state_t st_q;
	logic        is_term;
	logic        room;
	logic [4:0]  hex;

	assign is_term = (rx_byte == nlfc_pkg::CH_CR) || (rx_byte == nlfc_pkg::CH_LF);
	assign room    = st_q.len < LEN_MAX;
	assign hex     = nlfc_pkg::hex_digit(rx_byte);
	assign push    = rx_fire && is_term && (st_q.len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (rx_fire) begin
			if (is_term || !room) begin
				// terminator closes the line, overflow drops it
				st_q <= '0;
			end else begin
				st_q.len <= st_q.len + 1'b1;
				if (!st_q.nul) begin
					if (rx_byte == nlfc_pkg::CH_NUL) begin
						st_q.nul <= 1'b1;
					end else begin
						if (st_q.text_cnt != nlfc_pkg::TEXT_MIN)
							st_q.text_cnt <= st_q.text_cnt + 1'b1;
						if (st_q.len == '0) begin
							st_q.lead <= rx_byte;
						end else begin
							if (st_q.len == LEN_W'(nlfc_pkg::POS_TYPE0))
								st_q.letters[23:16] <= rx_byte;
							if (st_q.len == LEN_W'(nlfc_pkg::POS_TYPE1))
								st_q.letters[15:8] <= rx_byte;
							if (st_q.len == LEN_W'(nlfc_pkg::POS_TYPE2))
								st_q.letters[7:0] <= rx_byte;
							if (rx_byte == nlfc_pkg::CH_STAR) begin
								st_q.star_xor <= st_q.body_xor;
								st_q.star     <= 1'b1;
								st_q.tail_cnt <= '0;
								st_q.tail_hex <= '0;
								st_q.hex_end  <= 1'b0;
							end else if (st_q.star) begin
								if (st_q.tail_cnt != nlfc_pkg::TAIL_MIN)
									st_q.tail_cnt <= st_q.tail_cnt + 1'b1;
								if (!st_q.hex_end) begin
									if (hex[4])
										st_q.tail_hex <= {st_q.tail_hex[3:0], hex[3:0]};
									else
										st_q.hex_end <= 1'b1;
								end
							end
							st_q.body_xor <= st_q.body_xor ^ rx_byte;
						end
					end
				end
			end
		end
	end

	always_comb begin
		sum.lead_bang    = st_q.lead == nlfc_pkg::CH_BANG;
		sum.lead_dollar  = st_q.lead == nlfc_pkg::CH_DOLLAR;
		sum.text_ok      = st_q.text_cnt == nlfc_pkg::TEXT_MIN;
		sum.star_ok      = st_q.star && (st_q.tail_cnt == nlfc_pkg::TAIL_MIN);
		sum.star_xor     = st_q.star_xor;
		sum.tail_hex     = st_q.tail_hex;
		sum.type_letters = st_q.letters;
	end

	`NLFC_ASSERT_NOW(len_in_range, 1'b1, st_q.len <= LEN_MAX, "line length past limit")
	`NLFC_ASSERT_NEXT(push_clears_line, push, st_q.len == '0, "line not cleared after push")
	`NLFC_ASSERT_NOW(text_within_len, st_q.len < LEN_W'(nlfc_pkg::TEXT_MIN),
		LEN_W'(st_q.text_cnt) <= st_q.len, "text count exceeds line length")

endmodule

// ===== design/nlfc_queue.sv =====
// ----------------------------------------------------------------------------
// nlfc_queue
// two-entry queue of line summaries between framer and checker
// ----------------------------------------------------------------------------
`include "nmea_line_framer_checksum_assert.svh"

module nlfc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nlfc_pkg::line_sum_t wr_data,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output nlfc_pkg::line_sum_t head
);

	nlfc_pkg::line_sum_t               entries_q [nlfc_pkg::QDEPTH];
	logic [nlfc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [nlfc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [nlfc_pkg::QCNT_W-1:0]       cnt_q;

	assign full      = cnt_q == nlfc_pkg::QCNT_W'(nlfc_pkg::QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= wr_data;
	end

	`NLFC_ASSERT_NOW(no_overflow, push, !full, "push into full queue")
	`NLFC_ASSERT_NOW(no_underflow, pop, not_empty, "pop from empty queue")
	`NLFC_ASSERT_NOW(cnt_bound, 1'b1,
		cnt_q <= nlfc_pkg::QCNT_W'(nlfc_pkg::QDEPTH), "queue count out of range")

endmodule

// ===== design/nlfc_back.sv =====
// ----------------------------------------------------------------------------
// nlfc_back
// checker: turns a line summary into a verdict, kind, checksum and running totals,
// held in an output register
// ----------------------------------------------------------------------------
`include "nmea_line_framer_checksum_assert.svh"

module nlfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ais_enabled,
	input  logic                q_valid,
	input  nlfc_pkg::line_sum_t head,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [2:0]          verdict,
	output logic [3:0]          sentence_kind,
	output logic [7:0]          computed_sum,
	output logic [31:0]         good_total,
	output logic [31:0]         bad_total
);

	nlfc_pkg::verdict_t verdict_d;
	nlfc_pkg::kind_t    kind_d;
	logic [7:0]         sum_d;
	logic               good_d;

	logic               res_valid_q;
	logic [31:0]        good_q;
	logic [31:0]        bad_q;
	nlfc_pkg::verdict_t verdict_q;
	nlfc_pkg::kind_t    kind_q;
	logic [7:0]         sum_q;
	logic [31:0]        good_total_q;
	logic [31:0]        bad_total_q;

	assign pop = q_valid && (!res_valid_q || res_ready);

	always_comb begin
		kind_d    = nlfc_pkg::KIND_OTHER;
		sum_d     = 8'd0;
		verdict_d = nlfc_pkg::VERDICT_SHORT;
		if (head.lead_bang) begin
			verdict_d = ais_enabled ? nlfc_pkg::VERDICT_AIS_FWD : nlfc_pkg::VERDICT_AIS_REJ;
		end else if (!head.lead_dollar || !head.text_ok) begin
			verdict_d = nlfc_pkg::VERDICT_SHORT;
		end else if (!head.star_ok) begin
			verdict_d = nlfc_pkg::VERDICT_BAD_STAR;
		end else begin
			sum_d = head.star_xor;
			if (head.star_xor != head.tail_hex) begin
				verdict_d = nlfc_pkg::VERDICT_MISMATCH;
			end else begin
				verdict_d = nlfc_pkg::VERDICT_GOOD;
				kind_d    = nlfc_pkg::classify(head.type_letters);
			end
		end
		good_d = (verdict_d == nlfc_pkg::VERDICT_GOOD) ||
			(verdict_d == nlfc_pkg::VERDICT_AIS_FWD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			good_q      <= '0;
			bad_q       <= '0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
				if (good_d)
					good_q <= good_q + 32'd1;
				else
					bad_q <= bad_q + 32'd1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q    <= verdict_d;
			kind_q       <= kind_d;
			sum_q        <= sum_d;
			good_total_q <= good_d ? good_q + 32'd1 : good_q;
			bad_total_q  <= good_d ? bad_q : bad_q + 32'd1;
		end
	end

	assign res_valid     = res_valid_q;
	assign verdict       = verdict_q;
	assign sentence_kind = kind_q;
	assign computed_sum  = sum_q;
	assign good_total    = good_total_q;
	assign bad_total     = bad_total_q;

	`NLFC_ASSERT_NEXT(one_count_per_line, pop,
		(good_q + bad_q) == ($past(good_q + bad_q) + 32'd1), "totals not advanced by one")
	`NLFC_ASSERT_NOW(kind_only_when_good, res_valid_q && (kind_q != nlfc_pkg::KIND_OTHER),
		verdict_q == nlfc_pkg::VERDICT_GOOD, "sentence kind on a non-good line")
	`NLFC_ASSERT_NOW(sum_only_when_checked, res_valid_q && (sum_q != 8'd0),
		(verdict_q == nlfc_pkg::VERDICT_GOOD) || (verdict_q == nlfc_pkg::VERDICT_MISMATCH),
		"checksum shown on an unchecked line")

endmodule

// ===== design/nmea_line_framer_checksum.sv =====
// ----------------------------------------------------------------------------
// nmea_line_framer_checksum
// frames received bytes into nmea 0183 lines and checks each line's checksum
// ----------------------------------------------------------------------------
// usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one serial byte per request.
//   cr or lf closes a line; a non-empty line yields one result request on the
//   res channel (verdict, sentence_kind, computed_sum, good_total, bad_total).
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes ais_enabled; it is always
//   ready and should be written only while no line is in flight.
// throughput: one byte per cycle while the queue is not full, set by the framer's
//   registered running state update; a checker stage behind a two-entry queue keeps
//   pace at one line per cycle while res_ready is high.
// result path: the summary of a closed line is written into the queue when the
//   terminator is accepted, and the checker's output register takes it from the
//   queue head, raising res_valid, once that register is empty or res_ready is high.
// stall: while res_ready is low the output register holds its result and the
//   queue absorbs up to two more finished lines; rx_ready drops only when the
//   queue is full, so bytes that do not end a line keep flowing until then.
// reset: arst_n clears the line state, queue, totals and ais_enabled at once.
// ----------------------------------------------------------------------------
module nmea_line_framer_checksum #(
	parameter int LINE_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// received bytes
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	// ais enable register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// per-line results
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  verdict,
	output logic [3:0]  sentence_kind,
	output logic [7:0]  computed_sum,
	output logic [31:0] good_total,
	output logic [31:0] bad_total
);

	logic                ais_enabled_q;
	logic                rx_fire;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_valid;
	nlfc_pkg::line_sum_t line_sum;
	nlfc_pkg::line_sum_t q_head;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ais_enabled_q <= 1'b0;
		end else if (cfg_valid) begin
			ais_enabled_q <= cfg_data;
		end
	end

	// every byte is held off while the queue is full, as a terminator could find no slot
	assign rx_ready = !q_full;
	assign rx_fire  = rx_valid && rx_ready;

	// front: running line state, one summary per finished line
	nlfc_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_fire(rx_fire),
		.rx_byte(rx_byte),
		.push   (push),
		.sum    (line_sum)
	);

	// decoupling queue so each side stalls on its own
	nlfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (line_sum),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_valid),
		.head     (q_head)
	);

	// back: verdict, sentence type, totals and output register
	nlfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ais_enabled  (ais_enabled_q),
		.q_valid      (q_valid),
		.head         (q_head),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.verdict      (verdict),
		.sentence_kind(sentence_kind),
		.computed_sum (computed_sum),
		.good_total   (good_total),
		.bad_total    (bad_total)
	);

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// byte-stream test of the nmea line framer and checksum checker: a directed
// table of lines, length-limit lines and then random sentences and noise go in
// on the rx channel, an in-bench line model predicts each per-line result, and
// every result request is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_BYTES   = 128;
	localparam int RANDOM_BYTES = 520;
	localparam int RESULT_LAG   = 4;     // extra idle margin once every pending line has its result
	localparam int REPORT_LIMIT = 10;
	localparam int MIN_TEXT     = 7;
	localparam int MIN_TAIL     = 2;
	localparam int TAIL_CAP     = 127;
	localparam int NO_PIN       = -1;
	localparam logic [7:0] ZERO_MARK = 8'h7E;  // stands for a zero byte in table text

	localparam logic [23:0] KIND_CODES [10] = '{
		"HDT", "HDG", "VTG", "RMC", "MWV", "DBT", "DPT", "MTW", "XTE", "RMB"
	};

	typedef struct packed {
		nlfc_pkg::verdict_t verdict;
		nlfc_pkg::kind_t    kind;
		logic [7:0]         sum;
		logic [31:0]        good;
		logic [31:0]        bad;
	} line_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [2:0]  verdict;
	logic [3:0]  sentence_kind;
	logic [7:0]  computed_sum;
	logic [31:0] good_total;
	logic [31:0] bad_total;

	nmea_line_framer_checksum #(
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.verdict(verdict),
		.sentence_kind(sentence_kind),
		.computed_sum(computed_sum),
		.good_total(good_total),
		.bad_total(bad_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// line model: running state of the line being framed
	// ------------------------------------------------------------------------
	int unsigned held_len;    // bytes held, zero bytes and what follows included
	int unsigned text_len;    // bytes before the first zero byte
	int unsigned tail_len;    // characters after the last star
	logic [7:0]  lead_ch;
	logic [7:0]  run_xor;     // xor from position 1 on
	logic [7:0]  star_xor;    // run_xor as it stood at the last star
	logic [7:0]  tail_val;    // hex after the last star, low byte
	bit          star_seen;
	bit          hex_stop;
	bit          nul_hit;
	logic [23:0] letters;     // sentence type at positions 3..5
	logic [31:0] good_cnt = '0;
	logic [31:0] bad_cnt = '0;
	bit          ais_copy = 1'b0;

	line_result_t expected_lines [$];
	line_result_t oldest;
	int          mismatches = 0;

	// a directed row may type in its verdict; it replaces the model's one
	bit                 pin_on = 1'b0;
	nlfc_pkg::verdict_t pin_verdict = nlfc_pkg::VERDICT_GOOD;

	// idling controls
	bit          calm = 1'b0;
	int          hold_left = 0;

	// stimulus state
	logic [7:0]  line_buf [$];
	int          bytes_sent = 0;
	bit          ais_now = 1'b0;

	function automatic void clear_line_state();
		held_len = 0;
		text_len = 0;
		tail_len = 0;
		lead_ch = 8'h00;
		run_xor = 8'h00;
		star_xor = 8'h00;
		tail_val = 8'h00;
		star_seen = 1'b0;
		hex_stop = 1'b0;
		nul_hit = 1'b0;
		letters = 24'h0;
	endfunction

	initial clear_line_state();

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic nlfc_pkg::kind_t kind_of(input logic [23:0] l);
		for (int i = 0; i < 10; i++) begin
			if (l == KIND_CODES[i])
				return nlfc_pkg::kind_t'(i + 1);
		end
		return nlfc_pkg::KIND_OTHER;
	endfunction

	// one byte that does not end the line
	task automatic absorb_byte(input logic [7:0] c);
		int unsigned pos;
		int h;
		pos = held_len;
		held_len++;
		if (nul_hit)
			return;
		if (c == nlfc_pkg::CH_NUL) begin
			nul_hit = 1'b1;
			return;
		end
		text_len++;
		if (pos == 0) begin
			lead_ch = c;
			return;
		end
		if (pos >= 3 && pos <= 5)
			letters[8 * (5 - pos) +: 8] = c;
		if (c == nlfc_pkg::CH_STAR) begin
			star_xor = run_xor;
			star_seen = 1'b1;
			tail_len = 0;
			tail_val = 8'h00;
			hex_stop = 1'b0;
		end else if (star_seen) begin
			h = hex_nibble(c);
			if (tail_len < TAIL_CAP)
				tail_len++;
			if (!hex_stop) begin
				if (h >= 0)
					tail_val = {tail_val[3:0], h[3:0]};
				else
					hex_stop = 1'b1;
			end
		end
		run_xor ^= c;
	endtask

	// every accepted rx request goes through here
	task automatic predict_byte(input logic [7:0] c);
		line_result_t r;
		if (c != nlfc_pkg::CH_CR && c != nlfc_pkg::CH_LF) begin
			// overflow drops the byte and the line held so far
			if (held_len < LINE_BYTES - 1)
				absorb_byte(c);
			else
				clear_line_state();
		end else if (held_len != 0) begin
			r = '0;
			r.verdict = nlfc_pkg::VERDICT_GOOD;
			r.kind = nlfc_pkg::KIND_OTHER;
			if (lead_ch == nlfc_pkg::CH_BANG) begin
				if (ais_copy) begin
					r.verdict = nlfc_pkg::VERDICT_AIS_FWD;
					good_cnt++;
				end else begin
					r.verdict = nlfc_pkg::VERDICT_AIS_REJ;
					bad_cnt++;
				end
			end else if (lead_ch != nlfc_pkg::CH_DOLLAR || text_len < MIN_TEXT) begin
				r.verdict = nlfc_pkg::VERDICT_SHORT;
				bad_cnt++;
			end else if (!star_seen || tail_len < MIN_TAIL) begin
				r.verdict = nlfc_pkg::VERDICT_BAD_STAR;
				bad_cnt++;
			end else begin
				r.sum = star_xor;
				if (star_xor != tail_val) begin
					r.verdict = nlfc_pkg::VERDICT_MISMATCH;
					bad_cnt++;
				end else begin
					good_cnt++;
					r.kind = kind_of(letters);
				end
			end
			r.good = good_cnt;
			r.bad = bad_cnt;
			if (pin_on)
				r.verdict = pin_verdict;
			expected_lines.push_back(r);
			clear_line_state();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// monitor: requests are taken at the rising edge, pre-edge values
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_lines.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result request with no line pending", $realtime);
				end else begin
					oldest = expected_lines.pop_front();
					check_field("verdict", oldest.verdict, verdict);
					check_field("sentence_kind", oldest.kind, sentence_kind);
					check_field("computed_sum", oldest.sum, computed_sum);
					check_field("good_total", oldest.good, good_total);
					check_field("bad_total", oldest.bad, bad_total);
				end
			end
			if (cfg_valid && cfg_ready)
				ais_copy = cfg_data;
			if (rx_valid && rx_ready)
				predict_byte(rx_byte);
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side back-pressure, changed at the falling edge only
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			if (!calm)
				hold_left = pick_gap();
		end
	end

	// ------------------------------------------------------------------------
	// driver helpers; every task starts and ends at a falling edge
	// ------------------------------------------------------------------------
	// valid is left high on return so that a following byte goes straight on
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		@(negedge clk);
	endtask

	task automatic send_buf();
		foreach (line_buf[i]) begin
			send_byte(line_buf[i]);
			bytes_sent++;
		end
	endtask

	// hold the sender until every pending line has its result
	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(negedge clk);
		repeat (RESULT_LAG) @(negedge clk);
	endtask

	task automatic set_ais(input bit v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		ais_now = v;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 10)
			return 8'("0") + 8'(n);
		return (lower ? 8'("a") : 8'("A")) + 8'(n - 10);
	endfunction

	function automatic void push_hex(input logic [7:0] v, input bit lower);
		line_buf.push_back(hex_char(v[7:4], lower));
		line_buf.push_back(hex_char(v[3:0], lower));
	endfunction

	// xor of line_buf[1] up to, not including, line_buf[upto]
	function automatic logic [7:0] body_xor_upto(input int upto);
		logic [7:0] s;
		s = 8'h00;
		for (int i = 1; i < upto; i++)
			s ^= line_buf[i];
		return s;
	endfunction

	function automatic logic [7:0] field_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'("0") + 8'($urandom_range(0, 9));
		if (r < 55)
			return 8'(",");
		if (r < 62)
			return 8'(".");
		if (r < 85)
			return 8'("A") + 8'($urandom_range(0, 25));
		if (r < 88)
			return nlfc_pkg::CH_STAR;
		if (r < 90)
			return nlfc_pkg::CH_NUL;
		if (r < 95)
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(8'h80, 8'hFF));
	endfunction

	function automatic void push_term();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			line_buf.push_back(nlfc_pkg::CH_CR);
		end else if (r < 8) begin
			line_buf.push_back(nlfc_pkg::CH_LF);
		end else begin
			// cr lf: the lf closes an empty line
			line_buf.push_back(nlfc_pkg::CH_CR);
			line_buf.push_back(nlfc_pkg::CH_LF);
		end
	endfunction

	// one random line: mostly sentences with a checksum, some noise
	function automatic void make_line();
		int n;
		int k;
		int form;
		int r;
		logic [7:0] s;
		line_buf.delete();
		if ($urandom_range(0, 99) < 12) begin
			// raw noise, terminators inside it included
			n = $urandom_range(1, 14);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
			push_term();
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 88)
			line_buf.push_back(nlfc_pkg::CH_DOLLAR);
		else if (r < 96)
			line_buf.push_back(nlfc_pkg::CH_BANG);
		else
			line_buf.push_back(8'($urandom_range(8'h20, 8'hFF)));
		repeat (2) line_buf.push_back(8'("A") + 8'($urandom_range(0, 25)));
		if ($urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, 9);
			line_buf.push_back(KIND_CODES[k][23:16]);
			line_buf.push_back(KIND_CODES[k][15:8]);
			line_buf.push_back(KIND_CODES[k][7:0]);
		end else begin
			repeat (3) line_buf.push_back(8'("A") + 8'($urandom_range(0, 25)));
		end
		// now and then a line long enough to overflow
		n = ($urandom_range(0, 49) == 0) ? $urandom_range(118, 135) : $urandom_range(0, 24);
		repeat (n) line_buf.push_back(field_char());
		if ($urandom_range(0, 11) == 0) begin
			k = $urandom_range(1, 8);
			while (line_buf.size() > k)
				void'(line_buf.pop_back());
		end
		if ($urandom_range(0, 12) != 0) begin
			s = body_xor_upto(line_buf.size());
			line_buf.push_back(nlfc_pkg::CH_STAR);
			form = $urandom_range(0, 19);
			if (form < 12) begin
				line_buf.push_back(hex_char(s[7:4], 1'($urandom_range(0, 1))));
				line_buf.push_back(hex_char(s[3:0], 1'($urandom_range(0, 1))));
			end else if (form < 14) begin
				push_hex(s ^ 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
			end else if (form == 14) begin
				// one digit only
				line_buf.push_back(hex_char(s[3:0], 1'b0));
			end else if (form == 15) begin
				// extra leading digit, dropped by the modulo
				line_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
				push_hex(s, 1'($urandom_range(0, 1)));
			end else if (form == 16) begin
				// junk behind the digits
				push_hex(s, 1'b0);
				line_buf.push_back(8'(","));
				line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (form == 17) begin
				line_buf.push_back(8'("x"));
				line_buf.push_back(8'("y"));
			end else if (form == 18) begin
				// nothing after the star
			end else begin
				// 0x prefix is not honored
				line_buf.push_back(8'("0"));
				line_buf.push_back(8'("x"));
				push_hex(s, 1'b1);
			end
		end
		push_term();
	endfunction

	// ------------------------------------------------------------------------
	// directed table; a row ending in a star gets its correct checksum
	// appended, and a tilde in the text is sent as a zero byte
	// ------------------------------------------------------------------------
	localparam int DIR_ROWS = 26;

	string dir_text [DIR_ROWS] = '{
		"",                                    // empty line, no result
		"$GPHDT,123.4,T*",
		"$HCHDG,98.3,0.0,E,12.6,W*",
		"$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K*",
		"$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*",
		"$WIMWV,214.8,R,0.1,K,A*",
		"$SDDBT,7.8,f,2.4,M,1.3,F*",
		"$SDDPT,2.4,0.5*",
		"$YXMTW,17.75,C*",
		"$GPXTE,A,A,0.67,L,N*",
		"$GPRMB,A,0.66,L,003,004*",
		"$GPGGA,1*",                           // unknown type
		"!AIVDM,1,1,,A,13aG?P0P00,0*5C",       // ais while disabled
		"$GPHD",                               // too short
		"GPHDT,1*52",                          // no dollar
		"~$GPHDT,1*52",                        // led by a zero byte
		"$GPHDT,1",                            // no star
		"$GPHDT,1*5",                          // one char after star
		"$GPHDT,1*00",                         // wrong checksum
		"$GPHDT,1*0152x",                      // high digits and junk
		"$GPHDT,1*x52",                        // hex stops at once
		"$GP*HDT,1*",                          // last star counts
		"$GPHDT,1*52~zz",                      // tail hidden by zero byte
		"$\377\200\001HDT,ab*",                // high bytes in the body
		"!AIVDM,1,1,,B,x*00",                  // ais while enabled
		"$GPHDT,1*52"
	};

	bit dir_ais [DIR_ROWS] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1
	};

	logic [7:0] dir_term [DIR_ROWS] = '{
		nlfc_pkg::CH_LF, nlfc_pkg::CH_CR, nlfc_pkg::CH_LF, nlfc_pkg::CH_CR,
		nlfc_pkg::CH_CR, nlfc_pkg::CH_LF, nlfc_pkg::CH_CR, nlfc_pkg::CH_LF,
		nlfc_pkg::CH_CR, nlfc_pkg::CH_LF, nlfc_pkg::CH_CR, nlfc_pkg::CH_LF,
		nlfc_pkg::CH_CR, nlfc_pkg::CH_LF, nlfc_pkg::CH_CR, nlfc_pkg::CH_LF,
		nlfc_pkg::CH_CR, nlfc_pkg::CH_LF, nlfc_pkg::CH_CR, nlfc_pkg::CH_LF,
		nlfc_pkg::CH_CR, nlfc_pkg::CH_LF, nlfc_pkg::CH_CR, nlfc_pkg::CH_LF,
		nlfc_pkg::CH_CR, nlfc_pkg::CH_LF
	};

	int dir_pin [DIR_ROWS] = '{
		NO_PIN, nlfc_pkg::VERDICT_GOOD, NO_PIN, NO_PIN, NO_PIN, NO_PIN, NO_PIN, NO_PIN,
		NO_PIN, NO_PIN, NO_PIN, NO_PIN, nlfc_pkg::VERDICT_AIS_REJ, nlfc_pkg::VERDICT_SHORT,
		nlfc_pkg::VERDICT_SHORT, nlfc_pkg::VERDICT_SHORT, nlfc_pkg::VERDICT_BAD_STAR,
		nlfc_pkg::VERDICT_BAD_STAR, nlfc_pkg::VERDICT_MISMATCH, NO_PIN, NO_PIN, NO_PIN,
		NO_PIN, NO_PIN, nlfc_pkg::VERDICT_AIS_FWD, NO_PIN
	};

	bit phase_ais [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

	initial begin
		logic [7:0] b;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == 0 || dir_ais[i] != ais_now)
				set_ais(dir_ais[i]);
			line_buf.delete();
			for (int j = 0; j < dir_text[i].len(); j++) begin
				b = dir_text[i][j];
				line_buf.push_back(b == ZERO_MARK ? nlfc_pkg::CH_NUL : b);
			end
			if (line_buf.size() > 0 && line_buf[line_buf.size() - 1] == nlfc_pkg::CH_STAR)
				push_hex(body_xor_upto(line_buf.size() - 1), 1'b0);
			line_buf.push_back(dir_term[i]);
			pin_on = (dir_pin[i] != NO_PIN);
			if (pin_on)
				pin_verdict = nlfc_pkg::verdict_t'(dir_pin[i]);
			send_buf();
			pin_on = 1'b0;
		end

		// length limit: a full line, a line that overflows and then
		// restarts, and an overflow followed only by a terminator
		for (int v = 0; v < 3; v++) begin
			line_buf.delete();
			line_buf.push_back(nlfc_pkg::CH_DOLLAR);
			repeat (LINE_BYTES - 2) line_buf.push_back(8'("A"));
			if (v == 1) begin
				line_buf.push_back(8'("X"));
				for (int j = 0; j < dir_text[DIR_ROWS - 1].len(); j++)
					line_buf.push_back(dir_text[DIR_ROWS - 1][j]);
			end else if (v == 2) begin
				line_buf.push_back(8'("B"));
			end
			line_buf.push_back(v == 0 ? nlfc_pkg::CH_CR : nlfc_pkg::CH_LF);
			send_buf();
		end

		// random phases, ais setting flipped between them
		bytes_sent = 0;
		for (int p = 0; p < 4; p++) begin
			set_ais(phase_ais[p]);
			while (bytes_sent < (p + 1) * RANDOM_BYTES / 4) begin
				calm = ($urandom_range(0, 4) == 0);
				make_line();
				send_buf();
				// sender holds off now and then until the queue drains
				if ($urandom_range(0, 59) == 0)
					wait_drained();
			end
		end
		calm = 1'b0;

		wait_drained();
		if (mismatches == 0)
			$display("nmea_line_framer_checksum test passed");
		else
			$display("nmea_line_framer_checksum test failed");
		$finish;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("nmea_line_framer_checksum test failed");
		$finish;
	end

endmodule
